FILE: rtl/core/assert_macros.svh
// ------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds at the next edge after the antecedent
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/drld_pkg.sv
// ------------------------------------------------------------------
// drld_pkg
// types and constants of the data run list decoder
// ------------------------------------------------------------------
package drld_pkg;

	localparam int FIELD_BYTES = 4;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 32;
	localparam int LCN_W       = 32;
	localparam int VCN_W       = 48;
	localparam int CNT_W       = 3;
	localparam int POS_W       = 2;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_OFFSET = 2'd2,
		PH_HALTED = 2'd3
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] list_byte;
		logic              list_start;
	} list_beat_t;

	typedef struct packed {
		logic [LEN_W-1:0] run_length;
		logic [LCN_W-1:0] run_lcn;
		logic [VCN_W-1:0] start_vcn;
		logic             sparse_run;
		logic             list_end;
		logic             format_error;
	} run_t;

endpackage

FILE: rtl/core/drld_byte_if.sv
// ------------------------------------------------------------------
// drld_byte_if
// run list byte channel, valid/ready handshake
// ------------------------------------------------------------------
interface drld_byte_if;
	logic                          valid;
	logic                          ready;
	logic [drld_pkg::BYTE_W-1:0]   list_byte;
	logic                          list_start;

	modport source(output valid, output list_byte, output list_start, input ready);
	modport sink(input valid, input list_byte, input list_start, output ready);
endinterface

FILE: rtl/core/drld_run_if.sv
// ------------------------------------------------------------------
// drld_run_if
// decoded run channel, valid/ready handshake
// ------------------------------------------------------------------
interface drld_run_if;
	logic                          valid;
	logic                          ready;
	logic [drld_pkg::LEN_W-1:0]    run_length;
	logic [drld_pkg::LCN_W-1:0]    run_lcn;
	logic [drld_pkg::VCN_W-1:0]    start_vcn;
	logic                          sparse_run;
	logic                          list_end;
	logic                          format_error;

	modport source(output valid, output run_length, output run_lcn, output start_vcn,
		output sparse_run, output list_end, output format_error, input ready);
	modport sink(input valid, input run_length, input run_lcn, input start_vcn,
		input sparse_run, input list_end, input format_error, output ready);
endinterface

FILE: rtl/core/drld_parser.sv
// ------------------------------------------------------------------
// drld_parser
// run list state and single-byte step logic
// ------------------------------------------------------------------
module drld_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  drld_pkg::list_beat_t beat,
	output logic                 has_result,
	output drld_pkg::run_t       result
);

	drld_pkg::phase_t                phase_q, phase_c, phase_n;
	logic [drld_pkg::CNT_W-1:0]      len_left_q, len_left_c, len_left_n;
	logic [drld_pkg::CNT_W-1:0]      off_left_q, off_left_c, off_left_n;
	logic [drld_pkg::POS_W-1:0]      pos_q, pos_c, pos_n;
	logic [drld_pkg::LEN_W-1:0]      len_acc_q, len_acc_c, len_acc_n;
	logic [drld_pkg::LCN_W-1:0]      delta_acc_q, delta_acc_c, delta_acc_n;
	logic [drld_pkg::LCN_W-1:0]      prev_lcn_q, prev_lcn_c, prev_lcn_n;
	logic [drld_pkg::VCN_W-1:0]      next_vcn_q, next_vcn_c, next_vcn_n;

	logic [drld_pkg::BYTE_W-1:0]     b;
	logic [3:0]                      len_size, off_size;
	logic                            oversize, term_byte;
	logic [drld_pkg::LCN_W-1:0]      byte_ins, len_or, delta_or, delta_sx;
	logic [drld_pkg::LCN_W+1:0]      lcn_sum;
	logic                            lcn_bad;
	logic [drld_pkg::CNT_W-1:0]      len_left_dec;
	logic                            last_len, last_off;

	// list start wipes the running state before the byte is looked at
	always_comb begin
		if (beat.list_start) begin
			phase_c     = drld_pkg::PH_HEADER;
			len_left_c  = '0;
			off_left_c  = '0;
			pos_c       = '0;
			len_acc_c   = '0;
			delta_acc_c = '0;
			prev_lcn_c  = '0;
			next_vcn_c  = '0;
		end else begin
			phase_c     = phase_q;
			len_left_c  = len_left_q;
			off_left_c  = off_left_q;
			pos_c       = pos_q;
			len_acc_c   = len_acc_q;
			delta_acc_c = delta_acc_q;
			prev_lcn_c  = prev_lcn_q;
			next_vcn_c  = next_vcn_q;
		end
	end

	assign b         = beat.list_byte;
	assign len_size  = b[3:0] & drld_pkg::NIBBLE_MASK;
	assign off_size  = b[7:4] & drld_pkg::NIBBLE_MASK;
	assign oversize  = (len_size > 4'(drld_pkg::FIELD_BYTES))
		|| (off_size > 4'(drld_pkg::FIELD_BYTES));
	assign term_byte = (b == '0);

	assign byte_ins = {{(drld_pkg::LCN_W-drld_pkg::BYTE_W){1'b0}}, b} << {pos_c, 3'b000};
	assign len_or   = len_acc_c | byte_ins;
	assign delta_or = delta_acc_c | byte_ins;

	// sign extend from the last byte taken
	always_comb begin
		case (pos_c)
			2'd0:    delta_sx = {{24{delta_or[7]}}, delta_or[7:0]};
			2'd1:    delta_sx = {{16{delta_or[15]}}, delta_or[15:0]};
			2'd2:    delta_sx = {{8{delta_or[23]}}, delta_or[23:0]};
			default: delta_sx = delta_or;
		endcase
	end

	// negative or above 32 bits shows in the two top bits
	assign lcn_sum = {2'b00, prev_lcn_c} + {{2{delta_sx[drld_pkg::LCN_W-1]}}, delta_sx};
	assign lcn_bad = (lcn_sum[drld_pkg::LCN_W+1:drld_pkg::LCN_W] != 2'b00);

	assign len_left_dec = len_left_c - 3'd1;
	assign last_len     = (len_left_dec == '0);
	assign last_off     = (off_left_c <= 3'd1);

	// next phase
	always_comb begin
		unique case (phase_c)
			drld_pkg::PH_HEADER: begin
				if (term_byte || oversize)
					phase_n = drld_pkg::PH_HALTED;
				else if (len_size != 4'd0)
					phase_n = drld_pkg::PH_LENGTH;
				else
					phase_n = drld_pkg::PH_OFFSET;
			end
			drld_pkg::PH_LENGTH: begin
				if (!last_len)
					phase_n = drld_pkg::PH_LENGTH;
				else if (off_left_c == '0)
					phase_n = drld_pkg::PH_HEADER;
				else
					phase_n = drld_pkg::PH_OFFSET;
			end
			drld_pkg::PH_OFFSET: begin
				if (!last_off)
					phase_n = drld_pkg::PH_OFFSET;
				else if (lcn_bad)
					phase_n = drld_pkg::PH_HALTED;
				else
					phase_n = drld_pkg::PH_HEADER;
			end
			default: phase_n = drld_pkg::PH_HALTED;
		endcase
	end

	// data path and result
	always_comb begin
		len_left_n  = len_left_c;
		off_left_n  = off_left_c;
		pos_n       = pos_c;
		len_acc_n   = len_acc_c;
		delta_acc_n = delta_acc_c;
		prev_lcn_n  = prev_lcn_c;
		next_vcn_n  = next_vcn_c;
		has_result  = 1'b0;
		result      = '0;
		unique case (phase_c)
			drld_pkg::PH_HEADER: begin
				if (term_byte) begin
					has_result       = 1'b1;
					result.start_vcn = next_vcn_c;
					result.list_end  = 1'b1;
				end else if (oversize) begin
					has_result          = 1'b1;
					result.format_error = 1'b1;
				end else begin
					len_left_n  = len_size[drld_pkg::CNT_W-1:0];
					off_left_n  = off_size[drld_pkg::CNT_W-1:0];
					pos_n       = '0;
					len_acc_n   = '0;
					delta_acc_n = '0;
				end
			end
			drld_pkg::PH_LENGTH: begin
				len_acc_n  = len_or;
				len_left_n = len_left_dec;
				if (!last_len) begin
					pos_n = pos_c + 2'd1;
				end else begin
					pos_n = '0;
					if (off_left_c == '0) begin
						// sparse run
						has_result        = 1'b1;
						result.run_length = len_or;
						result.start_vcn  = next_vcn_c;
						result.sparse_run = 1'b1;
						next_vcn_n = next_vcn_c + {{(drld_pkg::VCN_W-drld_pkg::LEN_W){1'b0}}, len_or};
					end
				end
			end
			drld_pkg::PH_OFFSET: begin
				delta_acc_n = delta_or;
				if (!last_off) begin
					off_left_n = off_left_c - 3'd1;
					pos_n      = pos_c + 2'd1;
				end else begin
					off_left_n  = '0;
					delta_acc_n = delta_sx;
					has_result  = 1'b1;
					if (lcn_bad) begin
						result.format_error = 1'b1;
					end else begin
						pos_n             = '0;
						prev_lcn_n        = lcn_sum[drld_pkg::LCN_W-1:0];
						result.run_length = len_acc_c;
						result.run_lcn    = lcn_sum[drld_pkg::LCN_W-1:0];
						result.start_vcn  = next_vcn_c;
						next_vcn_n = next_vcn_c
							+ {{(drld_pkg::VCN_W-drld_pkg::LEN_W){1'b0}}, len_acc_c};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= drld_pkg::PH_HEADER;
			len_left_q  <= '0;
			off_left_q  <= '0;
			pos_q       <= '0;
			len_acc_q   <= '0;
			delta_acc_q <= '0;
			prev_lcn_q  <= '0;
			next_vcn_q  <= '0;
		end else if (step) begin
			phase_q     <= phase_n;
			len_left_q  <= len_left_n;
			off_left_q  <= off_left_n;
			pos_q       <= pos_n;
			len_acc_q   <= len_acc_n;
			delta_acc_q <= delta_acc_n;
			prev_lcn_q  <= prev_lcn_n;
			next_vcn_q  <= next_vcn_n;
		end
	end

endmodule

FILE: rtl/core/drld_out_reg.sv
// ------------------------------------------------------------------
// drld_out_reg
// result register holding one run until it is taken
// ------------------------------------------------------------------
module drld_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  drld_pkg::run_t next_run,
	input  logic           taken,
	output logic           valid,
	output drld_pkg::run_t run
);

	logic           valid_q;
	drld_pkg::run_t run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (taken) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= next_run;
		end
	end

	assign valid = valid_q;
	assign run   = run_q;

endmodule

FILE: rtl/core/data_run_list_decoder.sv
// ------------------------------------------------------------------
// data_run_list_decoder: run list bytes in, decoded runs out
// path: a beat is held in the input register, its run then in the result register
// throughput: 1 byte per cycle unless the sink stalls, set by the single-step parser
// reset: arst_n clears the parser state to header-await, LCN 0, VCN 0, no beats held
// ------------------------------------------------------------------
`include "assert_macros.svh"

module data_run_list_decoder (
	input  logic              clk,
	input  logic              arst_n,
	drld_byte_if.sink         list_ch,
	drld_run_if.source        run_ch
);

	// input register stage
	logic                 valid_s1;
	drld_pkg::list_beat_t beat_s1;

	// parser handshake
	logic                 advance;
	logic                 has_result;
	drld_pkg::run_t       result;

	// output register
	logic                 out_valid;
	drld_pkg::run_t       out_run;

	// the held byte steps the parser when the result register has room
	// for whatever it may produce (free now, or being emptied this edge)
	assign advance = valid_s1 && (!out_valid || run_ch.ready);

	// a new beat comes in whenever the input register is empty or moving on
	assign list_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (list_ch.valid && list_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (list_ch.valid && list_ch.ready) begin
			beat_s1.list_byte  <= list_ch.list_byte;
			beat_s1.list_start <= list_ch.list_start;
		end
	end

	// header / length / offset parsing, one byte per step
	drld_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.beat       (beat_s1),
		.has_result (has_result),
		.result     (result)
	);

	// runs, terminator and error results wait here for the sink
	drld_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && has_result),
		.next_run (result),
		.taken    (run_ch.ready),
		.valid    (out_valid),
		.run      (out_run)
	);

	assign run_ch.valid        = out_valid;
	assign run_ch.run_length   = out_run.run_length;
	assign run_ch.run_lcn      = out_run.run_lcn;
	assign run_ch.start_vcn    = out_run.start_vcn;
	assign run_ch.sparse_run   = out_run.sparse_run;
	assign run_ch.list_end     = out_run.list_end;
	assign run_ch.format_error = out_run.format_error;

	// a result is a run, a sparse run, a terminator or an error, never a mix
	`ASSERT_ALWAYS(a_kind_onehot, clk, arst_n, !out_valid || $onehot0({out_run.sparse_run, out_run.list_end, out_run.format_error}), "result carries more than one kind flag")

	// an error result carries nothing else
	`ASSERT_ALWAYS(a_error_clean, clk, arst_n, !(out_valid && out_run.format_error) || (out_run.run_length == '0 && out_run.run_lcn == '0 && out_run.start_vcn == '0), "error result has nonzero fields")

	// an accepted beat is held in the input register at the next edge
	`ASSERT_NEXT(a_beat_held, clk, arst_n, list_ch.valid && list_ch.ready, valid_s1, "accepted beat not captured")

	// the parser never steps into a full result register that is not draining
	`ASSERT_ALWAYS(a_no_overwrite, clk, arst_n, !(advance && out_valid && !run_ch.ready), "parser stepped while result stalled")

endmodule

FILE: dv/drld_run_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------
// drld_run_checker
// predicts decoded runs from accepted byte beats and compares them
// field by field with the run beats leaving the decoder
// ------------------------------------------------------------------
module drld_run_checker
	import drld_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	drld_byte_if  byte_mon,
	drld_run_if   run_mon,
	output int    fail_count,
	output int    runs_due,
	output int    run_count,
	output int    sparse_count,
	output int    end_count,
	output int    error_count
);

	localparam longint LCN_TOP = 64'h0000_0000_FFFF_FFFF;

	// decoder state as the predictor sees it
	phase_t           phase;
	logic [CNT_W-1:0] len_left;
	logic [CNT_W-1:0] ofs_left;
	logic [POS_W-1:0] field_pos;
	logic [LEN_W-1:0] len_acc;
	logic [LCN_W-1:0] delta_acc;
	logic [LCN_W-1:0] prev_lcn;
	logic [VCN_W-1:0] vcn_next;

	run_t pending_runs[$];
	run_t want_run;

	task automatic clear_list();
		phase     = PH_HEADER;
		len_left  = '0;
		ofs_left  = '0;
		field_pos = '0;
		len_acc   = '0;
		delta_acc = '0;
		prev_lcn  = '0;
		vcn_next  = '0;
	endtask

	task automatic push_error();
		pending_runs.push_back(run_t'{run_length: '0, run_lcn: '0, start_vcn: '0,
			sparse_run: 1'b0, list_end: 1'b0, format_error: 1'b1});
		phase = PH_HALTED;
	endtask

	task automatic emit_run(input logic [LCN_W-1:0] lcn, input logic sparse);
		pending_runs.push_back(run_t'{run_length: len_acc, run_lcn: lcn, start_vcn: vcn_next,
			sparse_run: sparse, list_end: 1'b0, format_error: 1'b0});
		vcn_next  = vcn_next + VCN_W'(len_acc);
		phase     = PH_HEADER;
		field_pos = '0;
	endtask

	task automatic decode_list_byte(input logic [BYTE_W-1:0] b, input logic start);
		logic [3:0] len_size;
		logic [3:0] ofs_size;
		int         width;
		longint     lcn;
		len_size = b[3:0] & NIBBLE_MASK;
		ofs_size = b[7:4] & NIBBLE_MASK;
		if (start)
			clear_list();
		case (phase)
		PH_HEADER: begin
			if (b == '0) begin
				pending_runs.push_back(run_t'{run_length: '0, run_lcn: '0,
					start_vcn: vcn_next, sparse_run: 1'b0, list_end: 1'b1,
					format_error: 1'b0});
				phase = PH_HALTED;
			end else if (len_size > FIELD_BYTES || ofs_size > FIELD_BYTES) begin
				push_error();
			end else begin
				len_left  = len_size[CNT_W-1:0];
				ofs_left  = ofs_size[CNT_W-1:0];
				field_pos = '0;
				len_acc   = '0;
				delta_acc = '0;
				phase     = (len_size != 0) ? PH_LENGTH : PH_OFFSET;
			end
		end
		PH_LENGTH: begin
			len_acc  = len_acc | (LEN_W'(b) << (8 * field_pos));
			len_left = len_left - 1'b1;
			if (len_left != 0) begin
				field_pos = field_pos + 1'b1;
			end else begin
				field_pos = '0;
				if (ofs_left == 0)
					emit_run('0, 1'b1);
				else
					phase = PH_OFFSET;
			end
		end
		PH_OFFSET: begin
			delta_acc = delta_acc | (LCN_W'(b) << (8 * field_pos));
			if (ofs_left > 1) begin
				ofs_left  = ofs_left - 1'b1;
				field_pos = field_pos + 1'b1;
			end else begin
				ofs_left = '0;
				width    = 8 * (int'(field_pos) + 1);
				// sign extension from the field's own width
				if (width < 32 && delta_acc[width-1])
					delta_acc = delta_acc | (32'hFFFF_FFFF << width);
				lcn = longint'({32'd0, prev_lcn}) + longint'({{32{delta_acc[31]}}, delta_acc});
				if (lcn < 0 || lcn > LCN_TOP) begin
					push_error();
				end else begin
					prev_lcn = lcn[LCN_W-1:0];
					emit_run(prev_lcn, 1'b0);
				end
			end
		end
		PH_HALTED: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [VCN_W-1:0] want,
		input logic [VCN_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: run %0d %s mismatch, expected %0h, actual %0h",
				$time, run_count, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_list();
			pending_runs.delete();
			fail_count   = 0;
			runs_due     = 0;
			run_count    = 0;
			sparse_count = 0;
			end_count    = 0;
			error_count  = 0;
		end else begin
			if (run_mon.valid && run_mon.ready) begin
				if (pending_runs.size() == 0) begin
					fail_count++;
					$display("%0t: run %0d unexpected, expected none, actual len %0h lcn %0h vcn %0h",
						$time, run_count, run_mon.run_length, run_mon.run_lcn,
						run_mon.start_vcn);
				end else begin
					want_run = pending_runs.pop_front();
					check_field("run_length", VCN_W'(want_run.run_length), VCN_W'(run_mon.run_length));
					check_field("run_lcn", VCN_W'(want_run.run_lcn), VCN_W'(run_mon.run_lcn));
					check_field("start_vcn", want_run.start_vcn, run_mon.start_vcn);
					check_field("sparse_run", VCN_W'(want_run.sparse_run), VCN_W'(run_mon.sparse_run));
					check_field("list_end", VCN_W'(want_run.list_end), VCN_W'(run_mon.list_end));
					check_field("format_error", VCN_W'(want_run.format_error),
						VCN_W'(run_mon.format_error));
				end
				run_count++;
				if (run_mon.sparse_run === 1'b1)
					sparse_count++;
				if (run_mon.list_end === 1'b1)
					end_count++;
				if (run_mon.format_error === 1'b1)
					error_count++;
			end
			if (byte_mon.valid && byte_mon.ready)
				decode_list_byte(byte_mon.list_byte, byte_mon.list_start);
			runs_due = pending_runs.size();
		end
	end

endmodule

FILE: dv/tb_data_run_list_decoder.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------
// tb_data_run_list_decoder
// drives run list byte beats into the decoder with random gaps and
// output stalls; a checker beside the block predicts every decoded
// run and counts mismatches, the top gives the verdict
// ------------------------------------------------------------------
module tb_data_run_list_decoder;
	import drld_pkg::*;

	localparam int     IDLE_PCT     = 8;
	localparam int     RANDOM_BEATS = 1600;
	localparam longint CYCLE_LIMIT  = 200_000;
	localparam longint LCN_TOP      = 64'h0000_0000_FFFF_FFFF;
	localparam int     DRAIN_CYCLES = 8;

	logic   clk;
	logic   arst_n;
	logic   idle_on;
	longint cycle_count = 0;
	int     beat_count  = 0;
	int     random_first;
	// lcn the stimulus believes the decoder holds, used to keep offsets in range
	longint cur_lcn;

	int fail_count;
	int runs_due;
	int run_count;
	int sparse_count;
	int end_count;
	int error_count;

	drld_byte_if byte_ch();
	drld_run_if  run_ch();

	data_run_list_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.list_ch(byte_ch),
		.run_ch (run_ch)
	);

	drld_run_checker run_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_mon    (byte_ch),
		.run_mon     (run_ch),
		.fail_count  (fail_count),
		.runs_due    (runs_due),
		.run_count   (run_count),
		.sparse_count(sparse_count),
		.end_count   (end_count),
		.error_count (error_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: random stalls, changed on the falling edge only
	always @(negedge clk) begin
		if (idle_on)
			run_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
		else
			run_ch.ready <= 1'b1;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d runs still due", cycle_count, runs_due);
			$display("simulation failed");
			$finish;
		end
	end

	// one byte beat, with random idle cycles in front of it; returns on the
	// falling edge after the beat was taken, so valid is touched once per step
	task automatic send_beat(input logic [BYTE_W-1:0] b, input logic start);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.list_byte  <= b;
		byte_ch.list_start <= start;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		@(negedge clk);
		beat_count++;
	endtask

	// header plus little-endian length and offset fields
	task automatic send_run(input int len_size, input int ofs_size, input logic [31:0] len,
		input logic [31:0] delta, input logic start);
		send_beat({4'(ofs_size), 4'(len_size)}, start);
		for (int i = 0; i < len_size; i++)
			send_beat(len[8*i +: 8], 1'b0);
		for (int i = 0; i < ofs_size; i++)
			send_beat(delta[8*i +: 8], 1'b0);
	endtask

	// one list: mostly well-formed runs with random content, now and then an
	// oversize header, an offset that may push the lcn out of range, or a run
	// cut short by the next list start
	task automatic send_random_list();
		int          runs;
		int          kind;
		int          len_size;
		int          ofs_size;
		int          cut;
		longint      span;
		longint      lo;
		longint      hi;
		longint      delta;
		logic [31:0] raw;
		logic [3:0]  big;
		logic [3:0]  other;
		logic        broken;
		logic        first;
		cur_lcn = 0;
		broken  = 1'b0;
		first   = 1'b1;
		runs    = $urandom_range(1, 6);
		for (int r = 0; r < runs && !broken; r++) begin
			kind     = $urandom_range(99);
			len_size = $urandom_range(4);
			ofs_size = $urandom_range(4);
			if (len_size == 0 && ofs_size == 0)
				ofs_size = 1;
			if (kind < 4) begin
				// one nibble asks for more than four bytes
				big   = 4'($urandom_range(FIELD_BYTES + 1, 15));
				other = 4'($urandom_range(15));
				if ($urandom_range(1))
					send_beat({big, other}, first);
				else
					send_beat({other, big}, first);
				broken = 1'b1;
			end else if (kind < 8) begin
				// raw offset bytes, the lcn may go negative or past 32 bits
				ofs_size = $urandom_range(1, FIELD_BYTES);
				raw      = $urandom;
				delta    = longint'(raw) & ((longint'(1) << (8 * ofs_size)) - 1);
				if (delta >= (longint'(1) << (8 * ofs_size - 1)))
					delta -= longint'(1) << (8 * ofs_size);
				send_run(len_size, ofs_size, $urandom, raw, first);
				if (cur_lcn + delta < 0 || cur_lcn + delta > LCN_TOP)
					broken = 1'b1;
				else
					cur_lcn += delta;
			end else if (kind < 11) begin
				// header and part of its fields only, then the next list begins
				cut = $urandom_range(0, len_size + ofs_size - 1);
				send_beat({4'(ofs_size), 4'(len_size)}, first);
				repeat (cut)
					send_beat(8'($urandom), 1'b0);
				broken = 1'b1;
			end else if (ofs_size == 0) begin
				send_run(len_size, 0, $urandom, '0, first);
			end else begin
				// offset kept inside the field's signed range and the lcn range,
				// with both bounds picked now and then
				span = longint'(1) << (8 * ofs_size - 1);
				lo   = (-cur_lcn > -span) ? -cur_lcn : -span;
				hi   = (LCN_TOP - cur_lcn < span - 1) ? LCN_TOP - cur_lcn : span - 1;
				case ($urandom_range(9))
				0: delta = lo;
				1: delta = hi;
				default: delta = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
				endcase
				cur_lcn += delta;
				send_run(len_size, ofs_size, $urandom, delta[31:0], first);
			end
			first = 1'b0;
		end
		if (!broken && $urandom_range(99) < 85)
			send_beat(8'h00, 1'b0);
		// stray bytes: ignored when halted, parsed otherwise
		if ($urandom_range(99) < 25)
			repeat ($urandom_range(1, 3))
				send_beat(8'($urandom), 1'b0);
	endtask

	initial begin
		arst_n             = 1'b0;
		idle_on            = 1'b1;
		byte_ch.valid      = 1'b0;
		byte_ch.list_byte  = '0;
		byte_ch.list_start = 1'b0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed part ----
		// first list has no start marker, the parser already waits for a header
		send_run(1, 1, 32'h0000_00FF, 32'h0000_0005, 1'b0);
		// sparse run of the largest length, lcn stays put
		send_run(4, 0, 32'hFFFF_FFFF, 32'h0, 1'b0);
		// empty length field still reports a run
		send_run(0, 1, 32'h0, 32'h0000_007F, 1'b0);
		// terminator, then a byte that the halted parser drops
		send_beat(8'h00, 1'b0);
		send_beat(8'h11, 1'b0);
		// oversize length nibble, then oversize offset nibble
		send_beat(8'h05, 1'b1);
		send_beat(8'h50, 1'b1);
		// widest positive offsets climb to the top, a small one passes 32 bits
		send_run(0, 4, 32'h0, 32'h7FFF_FFFF, 1'b1);
		send_run(0, 4, 32'h0, 32'h7FFF_FFFF, 1'b0);
		send_run(1, 1, 32'h0000_00FF, 32'h0000_0002, 1'b0);
		// negative one-byte offset from lcn zero goes below zero
		send_run(1, 1, 32'h0000_0001, 32'h0000_0080, 1'b1);

		// ---- random lists, with a long stretch free of idle cycles ----
		random_first = beat_count;
		while (beat_count - random_first < RANDOM_BEATS) begin
			idle_on = !(beat_count - random_first >= 600 && beat_count - random_first < 1000);
			send_random_list();
		end
		idle_on = 1'b1;

		// ---- drain ----
		byte_ch.valid <= 1'b0;
		while (runs_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);

		$display("%0d byte beats sent, %0d runs checked: %0d sparse, %0d list ends, %0d format errors",
			beat_count, run_count, sparse_count, end_count, error_count);
		$display("directed lists hit halting, oversize nibbles and both lcn range limits");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/drld_pkg.sv
rtl/core/drld_byte_if.sv
rtl/core/drld_run_if.sv
rtl/core/drld_parser.sv
rtl/core/drld_out_reg.sv
rtl/core/data_run_list_decoder.sv
dv/drld_run_checker.sv
dv/tb_data_run_list_decoder.sv
